// ===== design/wgwd_pkg.sv =====
// wave gesture window detector: shared constants, widths and types
// no dependencies; imported by wgwd_minmax and wave_gesture_window_detector_top
package wgwd_pkg;

   localparam int WINDOW_LEN = 10;
   localparam int COORD_W    = 9;
   localparam int CNT_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

   // request: tuser = {hand_tracked, elbow_tracked}, tdata = four coordinates
   localparam int REQ_USER_W   = 2;
   localparam int REQ_FIELDS_W = 4 * COORD_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;

   // response: tuser = window_updated, tdata = wave_detected, elbow_swing, hand_swing
   localparam int RSP_FIELDS_W = 1 + 2 * COORD_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam int CSR_IDX_W = 4;

   localparam logic [COORD_W-1:0] HAND_SWING_RESET  = COORD_W'(100);
   localparam logic [COORD_W-1:0] ELBOW_SWING_RESET = COORD_W'(50);

   localparam logic [CSR_IDX_W-1:0] REG_HAND_SWING_MIN  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_ELBOW_SWING_MAX = CSR_IDX_W'(1);

   // control from the sequencer to the min/max unit
   typedef struct packed {
      logic step;    // a sample is presented this cycle
      logic first;   // sample is the first of the scan
   } scan_ctl_type;

endpackage

// ===== design/wgwd_minmax.sv =====
// shared min/max tracker for the elbow and hand columns, one sample pair a cycle
// depends on wgwd_pkg
module wgwd_minmax (
   input  logic                          clock,
   input  wgwd_pkg::scan_ctl_type        ctl,
   input  logic [wgwd_pkg::COORD_W-1:0]  elbow_smp,
   input  logic [wgwd_pkg::COORD_W-1:0]  hand_smp,
   output logic [wgwd_pkg::COORD_W-1:0]  elbow_swing,
   output logic [wgwd_pkg::COORD_W-1:0]  hand_swing
);
   import wgwd_pkg::*;

   logic [COORD_W-1:0] elbow_lo_ff, elbow_hi_ff, hand_lo_ff, hand_hi_ff;
   logic [COORD_W-1:0] elbow_lo_in, elbow_hi_in, hand_lo_in, hand_hi_in;

   always_comb begin
      elbow_lo_in = elbow_lo_ff;
      elbow_hi_in = elbow_hi_ff;
      hand_lo_in  = hand_lo_ff;
      hand_hi_in  = hand_hi_ff;
      if (ctl.step) begin
         if (ctl.first || elbow_smp < elbow_lo_ff) elbow_lo_in = elbow_smp;
         if (ctl.first || elbow_smp > elbow_hi_ff) elbow_hi_in = elbow_smp;
         if (ctl.first || hand_smp < hand_lo_ff)   hand_lo_in  = hand_smp;
         if (ctl.first || hand_smp > hand_hi_ff)   hand_hi_in  = hand_smp;
      end
   end

   always_ff @(posedge clock) begin
      elbow_lo_ff <= elbow_lo_in;
      elbow_hi_ff <= elbow_hi_in;
      hand_lo_ff  <= hand_lo_in;
      hand_hi_ff  <= hand_hi_in;
   end

   assign elbow_swing = elbow_hi_ff - elbow_lo_ff;
   assign hand_swing  = hand_hi_ff - hand_lo_ff;

endmodule

// ===== design/wave_gesture_window_detector_top.sv =====
// wave gesture window detector top level: gating, window, scan sequencer, registers
// a frame that enters the window is answered after every window entry has passed through the
// shared min/max unit and the result is registered; a rejected frame skips the scan and its
// response is registered directly. no new request is taken until the response to the last one
// is registered, and later while a response waits. synchronous reset clears the window to zeros
// and the thresholds to 100/50
module wave_gesture_window_detector_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // bits from 0: elbow_x, elbow_y, hand_x, hand_y, zero pad
   input  logic [wgwd_pkg::REQ_DATA_W-1:0]  req_tdata,
   // bits from 0: elbow_tracked, hand_tracked
   input  logic [wgwd_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // bits from 0: wave_detected, elbow_swing, hand_swing, zero pad
   output logic [wgwd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // bit 0: window_updated
   output logic                             rsp_tuser,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [wgwd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [wgwd_pkg::COORD_W-1:0]     csr_wdata
);
   import wgwd_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   updated_ff, updated_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0]  rsp_tdata_ff, rsp_tdata_in;
   logic                   rsp_tuser_ff, rsp_tuser_in;
   logic [COORD_W-1:0]     hand_swing_min_ff, elbow_swing_max_ff;

   logic [COORD_W-1:0]     elbow_win_ff [WINDOW_LEN];
   logic [COORD_W-1:0]     hand_win_ff  [WINDOW_LEN];
   logic [COORD_W-1:0]     elbow_win_in [WINDOW_LEN];
   logic [COORD_W-1:0]     hand_win_in  [WINDOW_LEN];

   logic [COORD_W-1:0]     req_elbow_x, req_elbow_y, req_hand_x, req_hand_y;
   logic                   req_fire, req_pass;
   scan_ctl_type           scan_ctl;
   logic [COORD_W-1:0]     elbow_swing, hand_swing;
   logic                   wave;

   assign req_elbow_x = req_tdata[0*COORD_W +: COORD_W];
   assign req_elbow_y = req_tdata[1*COORD_W +: COORD_W];
   assign req_hand_x  = req_tdata[2*COORD_W +: COORD_W];
   assign req_hand_y  = req_tdata[3*COORD_W +: COORD_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_pass   = req_tuser[0] && req_tuser[1] && (req_hand_y < req_elbow_y);

   assign csr_ready  = 1'b1;

   // configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         hand_swing_min_ff  <= HAND_SWING_RESET;
         elbow_swing_max_ff <= ELBOW_SWING_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_HAND_SWING_MIN:  hand_swing_min_ff  <= csr_wdata;
            REG_ELBOW_SWING_MAX: elbow_swing_max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // window: shift in a passing frame, rotate once per scan cycle so entry 0 is the tap
   always_comb begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
         elbow_win_in[i] = elbow_win_ff[i];
         hand_win_in[i]  = hand_win_ff[i];
      end
      if ((req_fire && req_pass) || state_ff == ST_SCAN) begin
         for (int i = 0; i < WINDOW_LEN - 1; i++) begin
            elbow_win_in[i] = elbow_win_ff[i+1];
            hand_win_in[i]  = hand_win_ff[i+1];
         end
         if (state_ff == ST_SCAN) begin
            elbow_win_in[WINDOW_LEN-1] = elbow_win_ff[0];
            hand_win_in[WINDOW_LEN-1]  = hand_win_ff[0];
         end else begin
            elbow_win_in[WINDOW_LEN-1] = req_elbow_x;
            hand_win_in[WINDOW_LEN-1]  = req_hand_x;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
         if (reset) begin
            elbow_win_ff[i] <= '0;
            hand_win_ff[i]  <= '0;
         end else begin
            elbow_win_ff[i] <= elbow_win_in[i];
            hand_win_ff[i]  <= hand_win_in[i];
         end
      end
   end

   assign scan_ctl.step  = (state_ff == ST_SCAN);
   assign scan_ctl.first = (cnt_ff == '0);

   wgwd_minmax u_minmax (
      .clock       (clock),
      .ctl         (scan_ctl),
      .elbow_smp   (elbow_win_ff[0]),
      .hand_smp    (hand_win_ff[0]),
      .elbow_swing (elbow_swing),
      .hand_swing  (hand_swing)
   );

   assign wave = (hand_swing >= hand_swing_min_ff) && (elbow_swing <= elbow_swing_max_ff);

   // sequencer and response register
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      updated_in    = updated_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      if (rsp_tvalid_ff && rsp_tready) rsp_tvalid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               updated_in = req_pass;
               cnt_in     = '0;
               state_in   = req_pass ? ST_SCAN : ST_EMIT;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == CNT_W'(WINDOW_LEN - 1)) begin
               cnt_in   = '0;
               state_in = ST_EMIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            // wait for the output register to free up
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tuser_in  = updated_ff;
               if (updated_ff) begin
                  rsp_tdata_in = RSP_DATA_W'({hand_swing, elbow_swing, wave});
               end else begin
                  rsp_tdata_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         updated_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         updated_ff    <= updated_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

`ifndef SYNTHESIS
   // a rejected frame carries an all-zero payload
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("rejected frame with nonzero response payload");

   // a wave is only reported for a frame that entered the window
   a_wave_needs_update: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tuser)
      else $error("wave reported without window update");

   // scan counter rests at zero outside the scan
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_SCAN |-> cnt_ff == '0)
      else $error("scan counter not cleared outside scan");

   // a passing request always starts a scan
   a_pass_scans: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_pass |=> state_ff == ST_SCAN)
      else $error("passing request did not start a scan");
`endif

endmodule
